>>> rtl/core/copy_stream_until_delimiter_top_defines.svh
// Assertion macros for the copy_stream_until_delimiter block.
// Used by the port checker; depends on nothing else.
`ifndef COPY_STREAM_UNTIL_DELIMITER_TOP_DEFINES_SVH
`define COPY_STREAM_UNTIL_DELIMITER_TOP_DEFINES_SVH

// Property checked while out of reset.
`define CSUD_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal holds its value into the cycle after a condition, while out of reset.
`define CSUD_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

>>> rtl/core/csud_pkg.sv
// Shared types, codes and helpers for the copy_stream_until_delimiter block.
// No dependencies.
`default_nettype none

package csud_pkg;

    // parameter defaults
    localparam int MAX_DELIM_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int Q_DEPTH         = 4;

    // register widths and indexes
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DLEN_W     = 4;
    localparam int MAXC_W     = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 2'd2;

    // run status codes
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // flush count fits the largest delimiter less one
    localparam int FLUSH_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_new;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] status;
        logic       last_of_run;
    } t_out;

    // one classified word: held bytes to replay, then a final result
    typedef struct packed {
        logic [FLUSH_W-1:0] flush_n;
        logic [7:0]         data;
        logic               has;
        logic [1:0]         status;
    } t_cmd;

    // byte i of the delimiter register
    function automatic logic [7:0] delim_byte(input logic [CFG_DATA_W-1:0] d,
                                              input logic [DLEN_W-1:0] i);
        logic [2:0] sel;
        sel = i[2:0];
        return d[{3'd0, sel} * 8 +: 8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/csud_queue.sv
// Small register FIFO between the classifier and the result sequencer.
// Depends on csud_pkg.
`default_nettype none

module csud_queue #(
    parameter int DEPTH = csud_pkg::Q_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire csud_pkg::t_cmd i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output csud_pkg::t_cmd     o_data
);
    import csud_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/csud_front.sv
// Classifier: tracks match progress, byte count and run status per input word.
// Depends on csud_pkg.
`default_nettype none

module csud_front #(
    parameter int MAX_DELIM   = csud_pkg::MAX_DELIM_DEF,
    parameter int COUNT_WIDTH = csud_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire csud_pkg::t_in                   i_item,
    input  wire logic [csud_pkg::CFG_DATA_W-1:0] i_delim,
    input  wire logic [csud_pkg::DLEN_W-1:0]     i_delim_len,
    input  wire logic [csud_pkg::MAXC_W-1:0]     i_max_count,
    output logic                                 o_emit,
    output csud_pkg::t_cmd                       o_cmd
);
    import csud_pkg::*;

    localparam int MC_W = $clog2(MAX_DELIM + 1);
    localparam logic [DLEN_W-1:0] MAXD      = DLEN_W'(MAX_DELIM);
    localparam logic [DLEN_W-1:0] FLUSH_MAX = DLEN_W'(MAX_DELIM - 1);

    logic [MC_W-1:0]        r_mc;
    logic [COUNT_WIDTH-1:0] r_bc;
    logic [1:0]             r_rs;
    logic [MC_W-1:0]        n_mc;
    logic [COUNT_WIDTH-1:0] n_bc;
    logic [1:0]             n_rs;

    logic [MC_W-1:0]        mc_eff;
    logic [COUNT_WIDTH-1:0] bc_eff;
    logic [1:0]             rs_eff;
    logic [DLEN_W-1:0]      len;
    logic [DLEN_W-1:0]      mc_ext;
    logic [DLEN_W-1:0]      mc_inc;
    logic [DLEN_W-1:0]      flush;
    logic                   hit;
    logic [63:0]            max_ext;
    logic [COUNT_WIDTH-1:0] max_cw;

    // clamp overlong length, align the limit to the count width
    assign len     = (i_delim_len > MAXD) ? MAXD : i_delim_len;
    assign max_ext = {{(64 - MAXC_W){1'b0}}, i_max_count};
    assign max_cw  = max_ext[COUNT_WIDTH-1:0];

    // classify the word
    always_comb begin
        mc_eff = i_item.start_new ? '0 : r_mc;
        bc_eff = i_item.start_new ? '0 : r_bc;
        rs_eff = i_item.start_new ? ST_RUN : r_rs;
        mc_ext = DLEN_W'(mc_eff);
        mc_inc = mc_ext + 1'b1;
        flush  = (mc_ext > FLUSH_MAX) ? FLUSH_MAX : mc_ext;
        hit    = (len != '0) && (mc_ext < len)
                 && (i_item.data_byte == delim_byte(i_delim, mc_ext));
        n_mc   = mc_eff;
        n_bc   = bc_eff;
        n_rs   = rs_eff;
        o_emit = 1'b0;
        o_cmd  = '0;
        if (rs_eff != ST_RUN) begin
            // finished run: word is ignored, state kept
            o_emit       = 1'b1;
            o_cmd.status = ST_IGNORED;
        end else begin
            n_bc = bc_eff + 1'b1;
            if (hit) begin
                if (mc_inc == len) begin
                    n_mc         = '0;
                    n_rs         = ST_FOUND;
                    o_emit       = 1'b1;
                    o_cmd.status = ST_FOUND;
                end else begin
                    n_mc = MC_W'(mc_inc);
                end
            end else begin
                // mismatch: replay held prefix, then this byte
                n_mc          = '0;
                o_emit        = 1'b1;
                o_cmd.flush_n = FLUSH_W'(flush);
                o_cmd.data    = i_item.data_byte;
                o_cmd.has     = 1'b1;
                o_cmd.status  = ST_RUN;
            end
            if (n_rs == ST_RUN && i_max_count != '0 && n_bc == max_cw) begin
                n_mc         = '0;
                n_rs         = ST_LIMIT;
                o_emit       = 1'b1;
                o_cmd.status = ST_LIMIT;
            end
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc <= '0;
            r_bc <= '0;
            r_rs <= ST_RUN;
        end else if (i_accept) begin
            r_mc <= n_mc;
            r_bc <= n_bc;
            r_rs <= n_rs;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/csud_back.sv
// Result sequencer: expands one classified word into its result words.
// Depends on csud_pkg.
`default_nettype none

module csud_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire csud_pkg::t_cmd                  i_q_data,
    output logic                                 o_q_pop,
    input  wire logic [csud_pkg::CFG_DATA_W-1:0] i_delim,
    input  wire logic                            i_pop,
    output logic                                 o_empty,
    output csud_pkg::t_out                       o_result
);
    import csud_pkg::*;

    logic               r_valid;
    t_cmd               r_cmd;
    logic [FLUSH_W-1:0] r_idx;
    logic               last;
    logic               taken;

    assign last    = (r_idx == r_cmd.flush_n);
    assign taken   = r_valid && i_pop;
    assign o_empty = !r_valid;
    assign o_q_pop = i_q_valid && (!r_valid || (taken && last));

    // current result word
    always_comb begin
        o_result.out_byte    = last ? r_cmd.data
                                    : delim_byte(i_delim, DLEN_W'(r_idx));
        o_result.has_byte    = last ? r_cmd.has : 1'b1;
        o_result.status      = r_cmd.status;
        o_result.last_of_run = last;
    end

    // step through held bytes, load next word after the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (taken && !last) begin
            r_idx <= r_idx + 1'b1;
        end else if (!r_valid || taken) begin
            r_valid <= i_q_valid;
            r_idx   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/copy_stream_until_delimiter_top.sv
// Top level of the stream copy block: configuration registers, classifier,
// word queue and result sequencer. Depends on csud_pkg, csud_front,
// csud_queue and csud_back.
//
// Usage: one byte word is accepted per cycle while full is low. Each word
// gives zero results (byte held as part of a delimiter match), one result,
// or, when it breaks a partial match of k held bytes, k+1 results. The
// sequencer hands out one result per cycle while pop is high, and a
// four-word queue between the two sides absorbs runs of results before
// full rises. A word's results pass through the queue and then the
// sequencer's result register before they reach the result ports.
// The user writes registers through i_cfg_we/i_cfg_idx/i_cfg_data only
// while no word is in flight; the block itself does not enforce this. An
// index beyond the list is ignored.
`default_nettype none

module copy_stream_until_delimiter_top #(
    parameter int MAX_DELIM   = csud_pkg::MAX_DELIM_DEF,
    parameter int COUNT_WIDTH = csud_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [csud_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [csud_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire csud_pkg::t_in                   i_item,
    output logic                                 empty,
    input  wire logic                            pop,
    output csud_pkg::t_out                       o_result
);
    import csud_pkg::*;

    logic [CFG_DATA_W-1:0] r_delim;
    logic [DLEN_W-1:0]     r_delim_len;
    logic [MAXC_W-1:0]     r_max_count;

    logic accept;
    logic emit;
    t_cmd cmd;
    logic q_valid;
    logic q_pop;
    t_cmd q_data;

    assign accept = push && !full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= '0;
            r_delim_len <= '0;
            r_max_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELIM:     r_delim     <= i_cfg_data;
                CFG_DELIM_LEN: r_delim_len <= i_cfg_data[DLEN_W-1:0];
                CFG_MAX_COUNT: r_max_count <= i_cfg_data[MAXC_W-1:0];
                default: ;
            endcase
        end
    end

    csud_front #(
        .MAX_DELIM   (MAX_DELIM),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_delim     (r_delim),
        .i_delim_len (r_delim_len),
        .i_max_count (r_max_count),
        .o_emit      (emit),
        .o_cmd       (cmd)
    );

    csud_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && emit),
        .i_data  (cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    csud_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_delim   (r_delim),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/csud_checker.sv
// Port checker for copy_stream_until_delimiter_top, bound to the top level.
// Depends on csud_pkg and copy_stream_until_delimiter_top_defines.svh.
`default_nettype none
`include "copy_stream_until_delimiter_top_defines.svh"

module csud_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           empty,
    input wire logic           pop,
    input wire csud_pkg::t_out o_result
);
    import csud_pkg::*;

    // a waiting result word holds until taken
    `CSUD_HOLD(a_hold, i_clk, i_rst_n, !empty && !pop, o_result, "result changed while waiting")

    // a word without a byte always closes its input's results
    `CSUD_CHECK(a_nobyte_last, i_clk, i_rst_n, (!empty && !o_result.has_byte) |-> o_result.last_of_run, "byte-less word not last")

    // ignored input carries no byte
    `CSUD_CHECK(a_ign_nobyte, i_clk, i_rst_n, (!empty && o_result.status == ST_IGNORED) |-> !o_result.has_byte, "ignored word has byte")

    // delimiter found gives a single byte-less word
    `CSUD_CHECK(a_found_nobyte, i_clk, i_rst_n, (!empty && o_result.status == ST_FOUND) |-> (!o_result.has_byte && o_result.last_of_run), "found word malformed")

    // a word without a byte shows a zero byte
    `CSUD_CHECK(a_nobyte_zero, i_clk, i_rst_n, (!empty && !o_result.has_byte) |-> (o_result.out_byte == 8'd0), "byte-less word nonzero")

endmodule

bind copy_stream_until_delimiter_top csud_checker u_csud_checker (.*);

`default_nettype wire
